FILE: rtl/bvs_pkg.sv
// Package with shared constants and register codes for the battery voltage smoother.
`timescale 1ns / 1ps
`default_nettype none
package bvs_pkg;

   // Field widths.
   localparam int SampleWidth = 12;
   localparam int MvWidth     = 14;
   localparam int LevelWidth  = 7;
   localparam int FactorWidth = 16;
   localparam int StepWidth   = 10;
   localparam int FracBits    = 16;
   localparam int SmoothWidth = MvWidth + FracBits;

   // Configuration port.
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   typedef enum logic [1:0] {
      REG_SMOOTH_FACTOR = 2'd0,
      REG_CHARGE_MIN    = 2'd1,
      REG_STEP_THRESH   = 2'd2
   } reg_index_type;

   // Register reset values.
   localparam logic [FactorWidth-1:0] SmoothFactorReset = 16'd6554;
   localparam logic [MvWidth-1:0]     ChargeMinReset    = 14'd3300;
   localparam logic [StepWidth-1:0]   StepThreshReset   = 10'd10;

   // Charge level span, in Q14.16 millivolts.
   localparam logic [SmoothWidth-1:0] LevelLow  = 30'(3000) << FracBits;
   localparam logic [SmoothWidth-1:0] LevelHigh = 30'(4200) << FracBits;
   localparam logic [LevelWidth-1:0]  LevelFull = 7'd100;

   // Reciprocal of three, scaled by 2^11, for values up to 300.
   localparam logic [9:0] ThirdRecip = 10'd683;
   localparam int         ThirdShift = 11;

endpackage
`default_nettype wire

FILE: rtl/battery_voltage_smoother.sv
// Battery voltage smoother: EMA of the battery voltage, charge level and charging flag.
`timescale 1ns / 1ps
`default_nettype none
// Each request carries a converter reading in millivolts; the battery voltage is three
// times that value. The first good reading seeds the smoothed value, later ones move it
// by the programmed factor and update the charging flag. A request with read_ok low
// leaves the state alone. Every request gives exactly one result: smoothed millivolts,
// a 0 to 100 charge level and the charging flag. The block takes one request per clock
// while the result side does not stall; a request passes through an input register, the
// state update with its two multipliers, and the charge level stage ahead of the output
// register. Stalls on the result side back up through the three stages.
module battery_voltage_smoother (
   input  wire                                 clock,
   input  wire                                 reset,
   // Requests.
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [15:0]                         req_tdata,  // [11:0] sample_mv, rest zero
   input  wire                                 req_tuser,  // [0] read_ok
   // Results.
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [23:0]                         rsp_tdata,  // [13:0] smoothed_mv,
                                                           // [20:14] level_percent, rest zero
   output logic                                rsp_tuser,  // [0] charging
   // Configuration.
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [bvs_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  wire  [bvs_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [bvs_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int MW = bvs_pkg::MvWidth;
   localparam int SW = bvs_pkg::SmoothWidth;
   localparam int FW = bvs_pkg::FactorWidth;
   localparam int TW = bvs_pkg::StepWidth;
   localparam int FB = bvs_pkg::FracBits;

   // Configuration registers.
   logic [FW-1:0] factor_ff, factor_in;
   logic [MW-1:0] charge_min_ff, charge_min_in;
   logic [TW-1:0] step_ff, step_in;
   logic          csr_write;
   bvs_pkg::reg_index_type csr_index;

   // Pipeline stages.
   logic                              in_valid_ff, in_valid_in;
   logic [bvs_pkg::SampleWidth-1:0]   in_sample_ff, in_sample_in;
   logic                              in_ok_ff, in_ok_in;
   logic                              mid_valid_ff, mid_valid_in;
   logic [SW-1:0]                     mid_smooth_ff, mid_smooth_in;
   logic                              mid_charge_ff, mid_charge_in;
   logic                              out_valid_ff, out_valid_in;
   logic [MW-1:0]                     out_mv_ff, out_mv_in;
   logic [bvs_pkg::LevelWidth-1:0]    out_level_ff, out_level_in;
   logic                              out_charge_ff, out_charge_in;

   // Smoother state.
   logic [SW-1:0] smooth_ff, smooth_in;
   logic [MW-1:0] prev_ff, prev_in;
   logic          seeded_ff, seeded_in;
   logic          charge_ff, charge_in;

   logic out_en, mid_en, in_en, update;

   // Update datapath.
   logic [MW-1:0]      volt;
   logic [FW:0]        keep_weight;
   logic [SW+FW:0]     keep_prod;
   logic [SW-1:0]      add_prod;
   logic [SW+1:0]      ema_sum;
   logic [MW:0]        rise_limit, fall_limit;
   logic               rising, falling;

   // Level datapath.
   logic [SW-1:0]      level_off;
   logic [8:0]         level_quarter;
   logic [18:0]        level_prod;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = bvs_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      factor_in     = factor_ff;
      charge_min_in = charge_min_ff;
      step_in       = step_ff;
      csr_prdata    = '0;
      if (csr_write) begin
         case (csr_index)
            bvs_pkg::REG_SMOOTH_FACTOR: factor_in     = csr_pwdata[FW-1:0];
            bvs_pkg::REG_CHARGE_MIN:    charge_min_in = csr_pwdata[MW-1:0];
            bvs_pkg::REG_STEP_THRESH:   step_in       = csr_pwdata[TW-1:0];
            default: ;
         endcase
      end
      case (csr_index)
         bvs_pkg::REG_SMOOTH_FACTOR: csr_prdata = 32'(factor_ff);
         bvs_pkg::REG_CHARGE_MIN:    csr_prdata = 32'(charge_min_ff);
         bvs_pkg::REG_STEP_THRESH:   csr_prdata = 32'(step_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // Each stage moves on when the stage after it is empty or moving.
   assign out_en     = !out_valid_ff || rsp_tready;
   assign mid_en     = !mid_valid_ff || out_en;
   assign in_en      = !in_valid_ff || mid_en;
   assign req_tready = in_en;
   assign update     = in_valid_ff && mid_en;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      in_ok_in     = in_ok_ff;
      if (in_en) begin
         in_valid_in  = req_tvalid;
         in_sample_in = req_tdata[bvs_pkg::SampleWidth-1:0];
         in_ok_in     = req_tuser;
      end
   end

   // State update for the request in the input register.
   always_comb begin
      volt        = {1'b0, in_sample_ff, 1'b0} + {2'b00, in_sample_ff};
      keep_weight = (FW+1)'(1 << FB) - {1'b0, factor_ff};
      keep_prod   = (SW+FW+1)'(smooth_ff) * (SW+FW+1)'(keep_weight);
      add_prod    = SW'(volt) * SW'(factor_ff);
      ema_sum     = (SW+2)'(keep_prod[SW+FW:FB]) + (SW+2)'(add_prod);
      rise_limit  = {1'b0, prev_ff} + (MW+1)'(step_ff);
      fall_limit  = {1'b0, volt} + (MW+1)'(step_ff);
      rising      = {1'b0, volt} > rise_limit;
      falling     = fall_limit < {1'b0, prev_ff};

      smooth_in = smooth_ff;
      prev_in   = prev_ff;
      seeded_in = seeded_ff;
      charge_in = charge_ff;
      if (update && in_ok_ff) begin
         prev_in = volt;
         if (!seeded_ff) begin
            smooth_in = {volt, FB'(0)};
            seeded_in = 1'b1;
         end else begin
            smooth_in = ema_sum[SW-1:0];
            if (rising && (volt > charge_min_ff)) begin
               charge_in = 1'b1;
            end else if (falling || (volt < charge_min_ff)) begin
               charge_in = 1'b0;
            end
         end
      end

      mid_valid_in  = mid_valid_ff;
      mid_smooth_in = mid_smooth_ff;
      mid_charge_in = mid_charge_ff;
      if (mid_en) begin
         mid_valid_in  = in_valid_ff;
         mid_smooth_in = smooth_in;
         mid_charge_in = charge_in;
      end
   end

   // Charge level: floor((s - low) / (12 << 16)), done as a shift and a divide by three.
   always_comb begin
      level_off     = mid_smooth_ff - bvs_pkg::LevelLow;
      level_quarter = level_off[FB+10:FB+2];
      level_prod    = 19'(level_quarter) * 19'(bvs_pkg::ThirdRecip);

      out_valid_in  = out_valid_ff;
      out_mv_in     = out_mv_ff;
      out_level_in  = out_level_ff;
      out_charge_in = out_charge_ff;
      if (out_en) begin
         out_valid_in  = mid_valid_ff;
         out_mv_in     = mid_smooth_ff[SW-1:FB];
         out_charge_in = mid_charge_ff;
         if (mid_smooth_ff < bvs_pkg::LevelLow) begin
            out_level_in = '0;
         end else if (mid_smooth_ff > bvs_pkg::LevelHigh) begin
            out_level_in = bvs_pkg::LevelFull;
         end else begin
            out_level_in = level_prod[bvs_pkg::ThirdShift+6:bvs_pkg::ThirdShift];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff     <= bvs_pkg::SmoothFactorReset;
         charge_min_ff <= bvs_pkg::ChargeMinReset;
         step_ff       <= bvs_pkg::StepThreshReset;
         in_valid_ff   <= 1'b0;
         mid_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         smooth_ff     <= '0;
         prev_ff       <= '0;
         seeded_ff     <= 1'b0;
         charge_ff     <= 1'b0;
      end else begin
         factor_ff     <= factor_in;
         charge_min_ff <= charge_min_in;
         step_ff       <= step_in;
         in_valid_ff   <= in_valid_in;
         mid_valid_ff  <= mid_valid_in;
         out_valid_ff  <= out_valid_in;
         smooth_ff     <= smooth_in;
         prev_ff       <= prev_in;
         seeded_ff     <= seeded_in;
         charge_ff     <= charge_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff  <= in_sample_in;
      in_ok_ff      <= in_ok_in;
      mid_smooth_ff <= mid_smooth_in;
      mid_charge_ff <= mid_charge_in;
      out_mv_ff     <= out_mv_in;
      out_level_ff  <= out_level_in;
      out_charge_ff <= out_charge_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_level_ff, out_mv_ff};
   assign rsp_tuser  = out_charge_ff;

endmodule
`default_nettype wire

FILE: tb/battery_voltage_smoother_tb.sv
// Self-checking testbench for the battery voltage smoother: predicted results against the stream.
`timescale 1ns / 1ps
module battery_voltage_smoother_tb;

   localparam int        LimitCycles = 2000;
   localparam int        PhaseItems  = 200;
   localparam int        RandPhases  = 6;
   localparam logic [1:0] RegSpare   = 2'd3;   // decoded by nothing, writes must be ignored

   typedef struct {
      logic [13:0] mv;
      logic [6:0]  level;
      logic        charging;
   } gauge_type;

   class gauge_scoreboard;
      gauge_type   pending_gauges[$];
      logic [15:0] factor;
      logic [13:0] charge_min;
      logic [9:0]  step_mv;
      logic [29:0] smoothed;
      logic [13:0] last_mv;
      logic        seeded;
      logic        charging;
      int          errors;
      int          requests;
      int          bad_reads;
      int          flag_changes;
      int          at_floor;
      int          at_full;
      int          in_span;

      function new();
         factor       = 16'd6554;
         charge_min   = 14'd3300;
         step_mv      = 10'd10;
         smoothed     = '0;
         last_mv      = '0;
         seeded       = 1'b0;
         charging     = 1'b0;
         errors       = 0;
         requests     = 0;
         bad_reads    = 0;
         flag_changes = 0;
         at_floor     = 0;
         at_full      = 0;
         in_span      = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("ERROR: %s", msg);
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            bvs_pkg::REG_SMOOTH_FACTOR: factor = value[15:0];
            bvs_pkg::REG_CHARGE_MIN:    charge_min = value[13:0];
            bvs_pkg::REG_STEP_THRESH:   step_mv = value[9:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         logic [31:0] value;
         value = '0;
         case (idx)
            bvs_pkg::REG_SMOOTH_FACTOR: value = 32'(factor);
            bvs_pkg::REG_CHARGE_MIN:    value = 32'(charge_min);
            bvs_pkg::REG_STEP_THRESH:   value = 32'(step_mv);
            default: ;
         endcase
         return value;
      endfunction

      function int pending();
         return pending_gauges.size();
      endfunction

      // Advance the gauge by one request and queue the result it must produce.
      function void note_request(logic [11:0] sample, logic ok);
         logic [13:0]     volts;
         longint unsigned keep;
         longint unsigned add;
         longint unsigned lo;
         longint unsigned hi;
         int              rise;
         logic            old_flag;
         gauge_type       want;
         requests++;
         volts    = 14'({2'b00, sample} * 14'd3);
         old_flag = charging;
         if (!ok) begin
            bad_reads++;
         end else if (!seeded) begin
            smoothed = {volts, 16'h0000};
            last_mv  = volts;
            seeded   = 1'b1;
         end else begin
            keep     = longint'(smoothed) * (longint'(65536) - longint'(factor));
            add      = (longint'(volts) << 16) * longint'(factor);
            smoothed = 30'((keep + add) >> 16);
            rise     = int'(volts) - int'(last_mv);
            if (rise > int'(step_mv) && volts > charge_min)
               charging = 1'b1;
            else if (rise < -int'(step_mv) || volts < charge_min)
               charging = 1'b0;
            last_mv = volts;
         end
         if (charging != old_flag) flag_changes++;
         lo = longint'(3000) << 16;
         hi = longint'(4200) << 16;
         want.mv       = smoothed[29:16];
         want.charging = charging;
         if (longint'(smoothed) < lo) begin
            want.level = 7'd0;
            at_floor++;
         end else if (longint'(smoothed) > hi) begin
            want.level = 7'd100;
            at_full++;
         end else begin
            want.level = 7'(((longint'(smoothed) - lo) * 100) / (hi - lo));
            in_span++;
         end
         pending_gauges.push_back(want);
      endfunction

      function void check_result(logic [23:0] data, logic user);
         gauge_type want;
         if (pending_gauges.size() == 0) begin
            flag($sformatf("result tdata=0x%06h with no request outstanding", data));
            return;
         end
         want = pending_gauges.pop_front();
         if (data[13:0] !== want.mv)
            flag($sformatf("smoothed_mv: expected %0d, got %0d", want.mv, data[13:0]));
         if (data[20:14] !== want.level)
            flag($sformatf("level_percent: expected %0d, got %0d", want.level, data[20:14]));
         if (user !== want.charging)
            flag($sformatf("charging: expected %0b, got %0b", want.charging, user));
         if (data[23:21] !== 3'b000)
            flag($sformatf("tdata padding: expected 0, got 0x%0h", data[23:21]));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata = '0;   // [11:0] sample_mv, rest zero
   logic                    req_tuser = 1'b0; // [0] read_ok
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [23:0]             rsp_tdata;        // [13:0] smoothed_mv, [20:14] level_percent
   logic                    rsp_tuser;        // [0] charging
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [bvs_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [bvs_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [bvs_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   gauge_scoreboard sb;
   bit              idle_on = 1'b1;
   int              idle_pct = 15;
   int              quiet_cycles = 0;
   int              settings_written = 0;
   int              stall_left = 0;

   battery_voltage_smoother i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Result side: check every accepted result, then pick ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if (stall_left == 0 && idle_on && $urandom_range(0, 99) < idle_pct)
         stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LimitCycles) begin
         $display("Timeout: no traffic for %0d cycles.", LimitCycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_request(logic [11:0] sample, logic ok);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, sample};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      sb.note_request(sample, ok);
   endtask

   // Write one register, then read it back.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      settings_written++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx != RegSpare && csr_prdata !== sb.reg_value(idx))
         sb.flag($sformatf("register %0d read back: expected 0x%0h, got 0x%0h",
                           idx, sb.reg_value(idx), csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Let the pipeline run dry before settings change.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_settings();
      logic [15:0] factor;
      logic [13:0] cmin;
      logic [9:0]  step;
      case ($urandom_range(0, 5))
         0:       factor = 16'd0;
         1:       factor = 16'hFFFF;
         2:       factor = 16'd1;
         default: factor = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
         0:       cmin = 14'd0;
         1:       cmin = 14'd12285;
         default: cmin = 14'($urandom_range(0, 12285));
      endcase
      case ($urandom_range(0, 7))
         0:       step = 10'd0;
         1:       step = 10'd1023;
         2:       step = 10'($urandom_range(0, 1023));
         default: step = 10'($urandom_range(0, 40));
      endcase
      csr_write(bvs_pkg::REG_SMOOTH_FACTOR, 32'(factor));
      csr_write(bvs_pkg::REG_CHARGE_MIN, 32'(cmin));
      csr_write(bvs_pkg::REG_STEP_THRESH, 32'(step));
   endtask

   initial begin
      int   walk;
      int   span;
      int   pick;
      logic [11:0] sample;
      logic ok;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: failed reads before any seed, seeding, charge set, keep and clear.
      send_request(12'hFFF, 1'b0);
      send_request(12'd0, 1'b0);
      send_request(12'd1400, 1'b1);
      send_request(12'd4095, 1'b1);
      send_request(12'd0, 1'b1);
      send_request(12'd2000, 1'b0);
      send_request(12'd1100, 1'b1);
      send_request(12'd1104, 1'b1);
      send_request(12'd1104, 1'b1);
      send_request(12'd1101, 1'b1);
      send_request(12'd1100, 1'b1);
      send_request(12'd1099, 1'b1);
      send_request(12'd1103, 1'b1);
      send_request(12'd1097, 1'b1);
      drain();

      // Nearly full weight on the new sample, lowest thresholds: level edges at 3000 and 4200 mV.
      csr_write(bvs_pkg::REG_SMOOTH_FACTOR, 32'hFFFF);
      csr_write(bvs_pkg::REG_CHARGE_MIN, 32'd0);
      csr_write(bvs_pkg::REG_STEP_THRESH, 32'd0);
      send_request(12'd1000, 1'b1);
      send_request(12'd1400, 1'b1);
      send_request(12'd1401, 1'b1);
      send_request(12'd999, 1'b1);
      send_request(12'd1200, 1'b1);
      send_request(12'd600, 1'b0);
      drain();

      // A zero factor freezes the average; the highest thresholds never allow charging.
      csr_write(bvs_pkg::REG_SMOOTH_FACTOR, 32'd0);
      csr_write(bvs_pkg::REG_CHARGE_MIN, 32'd12285);
      csr_write(bvs_pkg::REG_STEP_THRESH, 32'd1023);
      csr_write(RegSpare, 32'hFFFF_FFFF);
      send_request(12'd4095, 1'b1);
      send_request(12'd0, 1'b1);
      send_request(12'd4095, 1'b1);
      send_request(12'd2730, 1'b1);
      drain();

      for (int phase = 0; phase < RandPhases; phase++) begin
         random_settings();
         if (phase == RandPhases - 1) idle_on = 1'b0;
         idle_pct = (phase % 3 == 1) ? 0 : 8 + 8 * (phase % 2);
         walk = int'(sb.charge_min) / 3;
         // Walk steps straddle the step threshold so the flag sets, holds and clears.
         span = int'(sb.step_mv) / 3 + 3;
         for (int n = 0; n < PhaseItems; n++) begin
            pick = $urandom_range(0, 99);
            ok   = 1'b1;
            if (pick < 8) begin
               sample = 12'($urandom);
               ok     = 1'b0;
            end else if (pick < 20) begin
               sample = 12'($urandom_range(0, 4095));
            end else if (pick < 24) begin
               case ($urandom_range(0, 3))
                  0:       sample = 12'd0;
                  1:       sample = 12'hFFF;
                  2:       sample = 12'd1000;
                  default: sample = 12'd1400;
               endcase
            end else begin
               walk += $urandom_range(0, 2 * span) - span;
               if (walk < 0) walk = 0;
               if (walk > 4095) walk = 4095;
               sample = 12'(walk);
            end
            send_request(sample, ok);
         end
         drain();
      end

      if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
      $display("Run covered %0d requests (%0d failed reads) over %0d register writes,",
               sb.requests, sb.bad_reads, settings_written);
      $display("%0d charging flag changes; level at 0: %0d, at 100: %0d, in between: %0d.",
               sb.flag_changes, sb.at_floor, sb.at_full, sb.in_span);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches in total.", sb.errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/bvs_pkg.sv
rtl/battery_voltage_smoother.sv
tb/battery_voltage_smoother_tb.sv
